[sv/tsqp_pkg.sv]
package tsqp_pkg;

  localparam int ETA_STEPS = 125;
  localparam int Q_BITS = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int CW = 57;
  localparam int ZW = 34;
  localparam int PHI_W = 14;

  localparam logic [63:0] EXP_UP = 64'd17461907;
  localparam logic [63:0] EXP_DOWN = 64'd16119372;
  localparam logic [63:0] Q24_ONE = 64'd16777216;

  typedef enum logic [1:0] {
    REG_PT_MIN = 2'd0,
    REG_CODE_A = 2'd1,
    REG_CODE_B = 2'd2,
    REG_CODE_C = 2'd3
  } cfg_reg_t;

  typedef logic [31:0] eta_tab_t [1:ETA_STEPS];
  typedef logic signed [ZW-1:0] atan_tab_t [CORDIC_STEPS];

  // 4*sinh^2(d/50) in Q24
  function automatic eta_tab_t eta_table();
    eta_tab_t tab;
    logic [63:0] x;
    logic [63:0] y;
    x = Q24_ONE;
    y = Q24_ONE;
    for (int d = 1; d <= ETA_STEPS; d++) begin
      x = (x * EXP_UP + (Q24_ONE >> 1)) >> 24;
      y = (y * EXP_DOWN + (Q24_ONE >> 1)) >> 24;
      tab[d] = 32'(x + y - (Q24_ONE << 1));
    end
    return tab;
  endfunction

  localparam eta_tab_t ETA_T = eta_table();

  localparam atan_tab_t ATAN = '{
    34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
    34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
    34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
    34'sh000028BE6, 34'sh0000145F3, 34'sh000000A2FA, 34'sh00000517D,
    34'sh0000028BE, 34'sh00000145F, 34'sh000000A30, 34'sh000000518,
    34'sh00000028C, 34'sh000000146, 34'sh0000000A3, 34'sh000000051,
    34'sh000000029, 34'sh000000014, 34'sh00000000A, 34'sh000000005
  };

endpackage

[sv/track_select_quantize_pack.sv]
// Track selection and packing. One particle enters per clock and the results leave in order,
// one per clock; the pipeline length is set by the 32-stage restoring divider that forms
// pz^2/pt^2 for the eta bins, while the 28-stage azimuth CORDIC and the 8-stage pt bin search
// run beside it. A stall at the output holds the whole pipeline, nothing is dropped. A
// rejected particle still yields a result with tuser low and tdata zero. Registers may be
// written only while no particle is in flight; a write takes effect for particles accepted
// from the next cycle on.
module track_select_quantize_pack #(
  parameter int PHI_BITS = 14,
  parameter int BIN_LIMIT = 250
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // species[31:0], mom_x[55:32], mom_y[79:56], mom_z[103:80]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // track_word[31:0]
  output logic [0:0]   m_tuser,   // accepted[0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import tsqp_pkg::*;

  localparam int STAGES = 39;
  localparam int OK_DLY = 35;
  localparam int PT_DLY = 26;
  localparam int PHI_DLY = 7;

  logic [22:0] pt_min;
  logic [30:0] code_a;
  logic [30:0] code_b;
  logic [30:0] code_c;
  logic [45:0] pt_min_sq;

  logic       en;
  logic [STAGES:1] vld;

  logic [31:0]        species_1;
  logic signed [23:0] px_1;
  logic signed [23:0] py_1;
  logic signed [23:0] pz_1;

  logic [31:0]        apid;
  logic signed [47:0] pxx_w;
  logic signed [47:0] pyy_w;
  logic signed [47:0] pzz_w;
  logic        match_2;
  logic        charge_2;
  logic        pzneg_2;
  logic [46:0] pxx_2;
  logic [46:0] pyy_2;
  logic [46:0] pzz_2;

  logic [47:0] pt2_w;
  logic [47:0] pt2_3;
  logic [46:0] pz2_3;
  logic        ok_3;
  logic        charge_3;
  logic        pzneg_3;

  logic [54:0] pt_v [9];
  logic [7:0]  pt_b [9];

  logic [7:0]       eta_bin;
  logic             eta_rej;
  logic [PHI_W-1:0] phi_bin;

  logic [1:0]       okc_dly [OK_DLY];
  logic [7:0]       pt_dly  [PT_DLY];
  logic [PHI_W-1:0] phi_dly [PHI_DLY];

  logic [7:0] pt_cap;
  logic       pass;

  assign cfg_ready = 1'b1;
  assign en        = !vld[STAGES] || m_tready;
  assign s_tready  = en;
  assign m_tvalid  = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_min <= 23'd1229;
      code_a <= 31'd211;
      code_b <= 31'd321;
      code_c <= 31'd2212;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PT_MIN: pt_min <= cfg_data[22:0];
        REG_CODE_A: code_a <= cfg_data;
        REG_CODE_B: code_b <= cfg_data;
        REG_CODE_C: code_c <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pt_min_sq <= pt_min * pt_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-1:1], s_tvalid};
    end
  end

  // stage 1: capture
  always_ff @(posedge clk) begin
    if (en) begin
      species_1 <= s_tdata[31:0];
      px_1      <= s_tdata[55:32];
      py_1      <= s_tdata[79:56];
      pz_1      <= s_tdata[103:80];
    end
  end

  // stage 2: squares and species match
  assign apid  = species_1[31] ? 32'(-species_1) : species_1;
  assign pxx_w = px_1 * px_1;
  assign pyy_w = py_1 * py_1;
  assign pzz_w = pz_1 * pz_1;

  always_ff @(posedge clk) begin
    if (en) begin
      match_2  <= (apid == {1'b0, code_a}) || (apid == {1'b0, code_b})
               || (apid == {1'b0, code_c});
      charge_2 <= !species_1[31] && (species_1 != '0);
      pzneg_2  <= pz_1[23];
      pxx_2    <= pxx_w[46:0];
      pyy_2    <= pyy_w[46:0];
      pzz_2    <= pzz_w[46:0];
    end
  end

  // stage 3: pt^2 and the cuts other than eta
  assign pt2_w = {1'b0, pxx_2} + {1'b0, pyy_2};

  always_ff @(posedge clk) begin
    if (en) begin
      pt2_3    <= pt2_w;
      pz2_3    <= pzz_2;
      ok_3     <= match_2 && (pt2_w != '0) && (pt2_w >= 48'(pt_min_sq));
      charge_3 <= charge_2;
      pzneg_3  <= pzneg_2;
    end
  end

  // pt bin: largest b with b^2 * 2^24 <= 100 * pt^2, one bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      pt_v[0] <= 55'(pt2_3) * 55'd100;
      pt_b[0] <= '0;
    end
  end

  for (genvar j = 1; j <= 8; j++) begin : g_pt
    logic [7:0]  trial;
    logic [15:0] sq;
    logic        fits;
    assign trial = pt_b[j-1] | 8'(9'd1 << (8 - j));
    assign sq    = trial * trial;
    assign fits  = 55'({sq, 24'd0}) <= pt_v[j-1];
    always_ff @(posedge clk) begin
      if (en) begin
        pt_v[j] <= pt_v[j-1];
        pt_b[j] <= fits ? trial : pt_b[j-1];
      end
    end
  end

  tsqp_eta #(
    .BIN_LIMIT(BIN_LIMIT)
  ) u_eta (
    .clk    (clk),
    .en     (en),
    .pt2    (pt2_3),
    .pz2    (pz2_3),
    .pz_neg (pzneg_3),
    .eta_bin(eta_bin),
    .eta_rej(eta_rej)
  );

  tsqp_phi #(
    .PHI_BITS(PHI_BITS)
  ) u_phi (
    .clk    (clk),
    .en     (en),
    .px     (px_1),
    .py     (py_1),
    .phi_bin(phi_bin)
  );

  // align side results with the eta bin output
  always_ff @(posedge clk) begin
    if (en) begin
      okc_dly[0] <= {ok_3, charge_3};
      pt_dly[0]  <= pt_b[8];
      phi_dly[0] <= phi_bin;
      for (int i = 1; i < OK_DLY; i++) begin
        okc_dly[i] <= okc_dly[i-1];
      end
      for (int i = 1; i < PT_DLY; i++) begin
        pt_dly[i] <= pt_dly[i-1];
      end
      for (int i = 1; i < PHI_DLY; i++) begin
        phi_dly[i] <= phi_dly[i-1];
      end
    end
  end

  assign pt_cap = (pt_dly[PT_DLY-1] > 8'(BIN_LIMIT)) ? 8'(BIN_LIMIT) : pt_dly[PT_DLY-1];
  assign pass   = okc_dly[OK_DLY-1][1] && !eta_rej;

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= pass;
      m_tdata <= pass ? {okc_dly[OK_DLY-1][0], 1'b1, pt_cap, eta_bin, phi_dly[PHI_DLY-1]}
                      : '0;
    end
  end

endmodule

[sv/tsqp_eta.sv]
module tsqp_eta #(
  parameter int BIN_LIMIT = 250
) (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] pt2,
  input  logic [46:0] pz2,
  input  logic        pz_neg,
  output logic [7:0]  eta_bin,
  output logic        eta_rej
);
  import tsqp_pkg::*;

  localparam int RW = 80;
  localparam logic [127:0] CNT_MASK = ((128'd1 << ETA_STEPS) - 128'd1) & ~128'd1;
  localparam logic [8:0] NEG_BASE = 9'(ETA_STEPS - 1);
  localparam logic [8:0] POS_BASE = 9'(ETA_STEPS);

  logic [RW-1:0]     rem [Q_BITS+1];
  logic [47:0]       dd  [Q_BITS+1];
  logic [Q_BITS-1:0] quo [Q_BITS+1];
  logic              ovf [Q_BITS+1];
  logic              neg [Q_BITS+1];

  logic [127:0] ge_w;
  logic [127:0] gt_w;
  logic         rz;
  logic [127:0] thermo;
  logic         thermo_neg;
  logic         rej;
  logic [6:0]   cnt_w;
  logic [8:0]   bin_w;

  // q = floor(pz2 * 2^26 / pt2), restoring, one bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'({pz2, 26'd0});
      dd[0]  <= pt2;
      quo[0] <= '0;
      ovf[0] <= 54'(pz2) >= {pt2, 6'd0};
      neg[0] <= pz_neg;
    end
  end

  for (genvar k = 1; k <= Q_BITS; k++) begin : g_div
    logic [RW-1:0] sub;
    logic          take;
    assign sub  = RW'(dd[k-1]) << (Q_BITS - k);
    assign take = rem[k-1] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? rem[k-1] - sub : rem[k-1];
        quo[k] <= {quo[k-1][Q_BITS-2:0], take};
        dd[k]  <= dd[k-1];
        ovf[k] <= ovf[k-1];
        neg[k] <= neg[k-1];
      end
    end
  end

  always_comb begin
    ge_w = '0;
    gt_w = '0;
    rz   = rem[Q_BITS] == '0;
    for (int d = 1; d <= ETA_STEPS; d++) begin
      ge_w[d] = ovf[Q_BITS] || (quo[Q_BITS] >= ETA_T[d]);
      gt_w[d] = ge_w[d] && !(!ovf[Q_BITS] && (quo[Q_BITS] == ETA_T[d]) && rz);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      thermo     <= (neg[Q_BITS] ? gt_w : ge_w) & CNT_MASK;
      thermo_neg <= neg[Q_BITS];
      rej        <= ge_w[ETA_STEPS];
    end
  end

  // thermometer code, so the count falls out of a binary search
  always_comb begin
    cnt_w = '0;
    for (int s = 6; s >= 0; s--) begin
      if (thermo[7'(cnt_w + (7'd1 << s))]) begin
        cnt_w = 7'(cnt_w + (7'd1 << s));
      end
    end
    bin_w = thermo_neg ? NEG_BASE - 9'(cnt_w) : POS_BASE + 9'(cnt_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eta_bin <= (bin_w > 9'(BIN_LIMIT)) ? 8'(BIN_LIMIT) : bin_w[7:0];
      eta_rej <= rej;
    end
  end

endmodule

[sv/tsqp_phi.sv]
module tsqp_phi #(
  parameter int PHI_BITS = 14
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [23:0]         px,
  input  logic signed [23:0]         py,
  output logic [tsqp_pkg::PHI_W-1:0] phi_bin
);
  import tsqp_pkg::*;

  localparam logic signed [ZW-1:0] QTURN = ZW'(64'h4000_0000);
  localparam logic [32:0] PHI_CAP = (PHI_BITS >= PHI_W) ? 33'((64'd1 << PHI_W) - 64'd1)
                                                       : 33'((64'd1 << PHI_BITS) - 64'd1);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] cx [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
  logic signed [ZW:0]   u;
  logic [32:0]          uc;
  logic [32:0]          bn;

  assign xs = $signed({{(CW-54){px[23]}}, px, 30'd0});
  assign ys = $signed({{(CW-54){py[23]}}, py, 30'd0});

  always_ff @(posedge clk) begin
    if (en) begin
      if (xs[CW-1]) begin
        if (!ys[CW-1]) begin
          cx[0] <= ys;
          cy[0] <= -xs;
          cz[0] <= QTURN;
        end else begin
          cx[0] <= -ys;
          cy[0] <= xs;
          cz[0] <= -QTURN;
        end
      end else begin
        cx[0] <= xs;
        cy[0] <= ys;
        cz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][CW-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN[i];
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN[i];
        end
      end
    end
  end

  assign u = $signed({cz[CORDIC_STEPS][ZW-1], cz[CORDIC_STEPS]})
           + $signed({3'b000, 32'h8000_0000});

  always_comb begin
    if (u[ZW]) begin
      uc = '0;
    end else if (u > $signed(35'h1_0000_0000)) begin
      uc = 33'h1_0000_0000;
    end else begin
      uc = u[32:0];
    end
    bn = uc >> (32 - PHI_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi_bin <= (bn > PHI_CAP) ? PHI_CAP[PHI_W-1:0] : bn[PHI_W-1:0];
    end
  end

endmodule

[sv/tsqp_chk.sv]
module tsqp_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [31:0]  m_tdata,
  input logic [0:0]   m_tuser
);

  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("rejected transfer carries a nonzero word");

  a_quality: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[30])
    else $error("accepted transfer without quality bit");

  a_free_in: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output transfer changed");

endmodule

bind track_select_quantize_pack tsqp_chk u_chk (.*);
